### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the files that check their own logic.
// ----------------------------------------------------------------------------
// Every macro samples on the rising clock edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant does not hold");

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle check does not hold");

`endif

### sv/cmqb_pkg.sv
// ----------------------------------------------------------------------------
// Classed multi-queue buffer package
// Item types, codes and defaults shared by the controller, datapath and top.
// ----------------------------------------------------------------------------
package cmqb_pkg;

	localparam int NUM_ZONES_DEF      = 14;
	localparam int NUM_CLASSES_DEF    = 4;
	localparam int BUFFER_ENTRIES_DEF = 64;

	localparam int LIMIT_W   = 24;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SMALL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE  = 2'd2;

	// Threshold reset values: 0.005 m3, 0.02 m3 and 8 m3 in cubic centimeters.
	localparam logic [LIMIT_W-1:0] SMALL_RST  = 24'd5000;
	localparam logic [LIMIT_W-1:0] MEDIUM_RST = 24'd20000;
	localparam logic [LIMIT_W-1:0] LARGE_RST  = 24'd8000000;

	// Operation codes.
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// Result status codes.
	localparam logic [2:0] STAT_ENQUEUED = 3'd0;
	localparam logic [2:0] STAT_DEQUEUED = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_INVALID  = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;

	typedef struct packed {
		logic        func;
		logic [3:0]  zone;
		logic [23:0] volume;
		logic [2:0]  wanted_class;
		logic [31:0] amount_in;
		logic [30:0] merchant_in;
		logic [31:0] tag_in;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  class_out;
		logic [31:0] amount_out;
		logic [30:0] merchant_out;
		logic [31:0] tag_out;
	} rsp_item_t;

	// One stored buffer entry.
	typedef struct packed {
		logic [31:0] amount;
		logic [30:0] merchant;
		logic [31:0] tag;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic fetch;
		logic exec;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_fetch;
		logic out_busy;
	} dp_stat_t;

endpackage

### sv/cmqb_ctrl.sv
// ----------------------------------------------------------------------------
// Classed multi-queue buffer controller
// Sequences each item through accept, optional entry fetch and commit.
// ----------------------------------------------------------------------------
module cmqb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  cmqb_pkg::dp_stat_t stat,
	output cmqb_pkg::dp_cmd_t  cmd
);
	import cmqb_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall  = (state_q != S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && req_valid;
	assign cmd.fetch  = (state_q == S_FETCH);
	assign cmd.exec   = (state_q == S_EXEC) && !stat.out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = stat.need_fetch ? S_FETCH : S_EXEC;
				end
			end
			S_FETCH: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.exec) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/cmqb_datapath.sv
// ----------------------------------------------------------------------------
// Classed multi-queue buffer datapath
// Threshold registers, size classifier, queue pointer memories, entry buffer,
// free-slot stack and the result register.
// ----------------------------------------------------------------------------
module cmqb_datapath #(
	parameter int NUM_ZONES      = cmqb_pkg::NUM_ZONES_DEF,
	parameter int NUM_CLASSES    = cmqb_pkg::NUM_CLASSES_DEF,
	parameter int BUFFER_ENTRIES = cmqb_pkg::BUFFER_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmqb_pkg::req_item_t                  req_item,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output cmqb_pkg::rsp_item_t                  rsp_item,
	input  logic                                 cfg_we,
	input  logic [cmqb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmqb_pkg::LIMIT_W-1:0]         cfg_data,
	input  cmqb_pkg::dp_cmd_t                    cmd,
	output cmqb_pkg::dp_stat_t                   stat
);
	import cmqb_pkg::*;

	localparam int NUM_QUEUES = NUM_ZONES * NUM_CLASSES;
	localparam int QW = $clog2(NUM_QUEUES);
	localparam int SW = $clog2(BUFFER_ENTRIES);
	localparam int CW = $clog2(BUFFER_ENTRIES + 1);
	localparam logic [1:0]    MAX_CLS  = 2'(NUM_CLASSES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_ENTRIES);

	// Threshold registers.
	logic [LIMIT_W-1:0] small_q;
	logic [LIMIT_W-1:0] medium_q;
	logic [LIMIT_W-1:0] large_q;

	// Memories.
	logic [SW-1:0] head_mem  [NUM_QUEUES];
	logic [SW-1:0] tail_mem  [NUM_QUEUES];
	logic [SW-1:0] link_mem  [BUFFER_ENTRIES];
	entry_t        entry_mem [BUFFER_ENTRIES];
	logic [SW-1:0] free_mem  [BUFFER_ENTRIES];

	logic [NUM_QUEUES-1:0] nonempty_q;
	logic [CW-1:0]         fc_q;
	logic [CW-1:0]         low_q;

	// Registered read data.
	logic [SW-1:0] head_rd_q;
	logic [SW-1:0] tail_rd_q;
	logic [SW-1:0] link_rd_q;
	entry_t        entry_rd_q;
	logic [SW-1:0] free_rd_q;

	// Item held from acceptance to commit.
	logic          op_q;
	logic          ok_q;
	logic [1:0]    cls_q;
	logic [QW-1:0] qn_q;
	entry_t        data_q;
	logic [SW-1:0] fpos_q;
	logic          fidx_q;

	logic          rsp_valid_q;
	rsp_item_t     rsp_item_q;

	logic [1:0]    cls_raw;
	logic [1:0]    cls_enq;
	logic [1:0]    cls_sel;
	logic          zone_ok;
	logic          want_ok;
	logic          item_ok;
	int            qn_wide;
	logic [QW-1:0] qn_in;
	logic [CW-1:0] fc_dec;
	logic          ne_cur;
	logic          enq_go;
	logic          deq_go;
	logic          last_one;
	logic [SW-1:0] slot_enq;
	rsp_item_t     rsp_d;

	// Size class: tests run from the largest threshold down.
	always_comb begin
		if (req_item.volume > large_q) begin
			cls_raw = 2'd3;
		end else if (req_item.volume > medium_q) begin
			cls_raw = 2'd2;
		end else if (req_item.volume > small_q) begin
			cls_raw = 2'd1;
		end else begin
			cls_raw = 2'd0;
		end
		cls_enq = (cls_raw > MAX_CLS) ? MAX_CLS : cls_raw;
	end

	assign zone_ok = (req_item.zone != 4'd0) && (req_item.zone <= 4'(NUM_ZONES));
	assign want_ok = (req_item.wanted_class < 3'(NUM_CLASSES));
	assign cls_sel = (req_item.func == FUNC_DEQ) ? req_item.wanted_class[1:0] : cls_enq;
	assign item_ok = zone_ok && ((req_item.func == FUNC_ENQ) || want_ok);
	assign qn_wide = (int'(req_item.zone) - 1) * NUM_CLASSES + int'(cls_sel);
	assign qn_in   = qn_wide[QW-1:0];
	assign fc_dec  = fc_q - 1'b1;

	assign stat.need_fetch = (req_item.func == FUNC_DEQ) && item_ok && nonempty_q[qn_in];
	assign stat.out_busy   = rsp_valid_q && rsp_stall;

	assign ne_cur   = nonempty_q[qn_q];
	assign enq_go   = cmd.exec && (op_q == FUNC_ENQ) && ok_q && (fc_q != '0);
	assign deq_go   = cmd.exec && (op_q == FUNC_DEQ) && ok_q && ne_cur;
	assign last_one = (tail_rd_q == head_rd_q);
	// A stack position below the low mark was never written and still holds its index.
	assign slot_enq = fidx_q ? fpos_q : free_rd_q;

	always_comb begin
		rsp_d = '0;
		rsp_d.class_out = cls_q;
		if (op_q == FUNC_ENQ) begin
			if (!ok_q) begin
				rsp_d.status = STAT_INVALID;
			end else if (fc_q == '0) begin
				rsp_d.status = STAT_FULL;
			end else begin
				rsp_d.status = STAT_ENQUEUED;
			end
		end else begin
			if (!ok_q) begin
				rsp_d.status    = STAT_INVALID;
				rsp_d.class_out = 2'd0;
			end else if (!ne_cur) begin
				rsp_d.status = STAT_EMPTY;
			end else begin
				rsp_d.status       = STAT_DEQUEUED;
				rsp_d.amount_out   = entry_rd_q.amount;
				rsp_d.merchant_out = entry_rd_q.merchant;
				rsp_d.tag_out      = entry_rd_q.tag;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_q     <= SMALL_RST;
			medium_q    <= MEDIUM_RST;
			large_q     <= LARGE_RST;
			nonempty_q  <= '0;
			fc_q        <= FULL_CNT;
			low_q       <= FULL_CNT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SMALL:  small_q  <= cfg_data;
					REG_MEDIUM: medium_q <= cfg_data;
					REG_LARGE:  large_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (enq_go) begin
				nonempty_q[qn_q] <= 1'b1;
				fc_q             <= fc_q - 1'b1;
				if (fidx_q) begin
					low_q <= fc_q - 1'b1;
				end
			end
			if (deq_go) begin
				if (last_one) begin
					nonempty_q[qn_q] <= 1'b0;
				end
				if (fc_q < FULL_CNT) begin
					fc_q <= fc_q + 1'b1;
				end
			end
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, reads issued at acceptance and fetch, and the result register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= req_item.func;
			ok_q   <= item_ok;
			cls_q  <= cls_sel;
			qn_q   <= qn_in;
			data_q <= '{amount: req_item.amount_in, merchant: req_item.merchant_in,
				tag: req_item.tag_in};
			fpos_q <= fc_dec[SW-1:0];
			fidx_q <= (fc_dec < low_q);
			if (item_ok) begin
				head_rd_q <= head_mem[qn_in];
				tail_rd_q <= tail_mem[qn_in];
			end
			if (fc_q != '0) begin
				free_rd_q <= free_mem[fc_dec[SW-1:0]];
			end
		end
		if (cmd.fetch) begin
			link_rd_q  <= link_mem[head_rd_q];
			entry_rd_q <= entry_mem[head_rd_q];
		end
		if (cmd.exec) begin
			rsp_item_q <= rsp_d;
		end
	end

	// Memory writes at commit.
	always_ff @(posedge clk) begin
		if (enq_go) begin
			entry_mem[slot_enq] <= data_q;
			tail_mem[qn_q]      <= slot_enq;
			if (ne_cur) begin
				link_mem[tail_rd_q] <= slot_enq;
			end else begin
				head_mem[qn_q] <= slot_enq;
			end
		end
		if (deq_go) begin
			if (!last_one) begin
				head_mem[qn_q] <= link_rd_q;
			end
			if (fc_q < FULL_CNT) begin
				free_mem[fc_q[SW-1:0]] <= head_rd_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

### sv/classed_multi_queue_buffer_top.sv
// ----------------------------------------------------------------------------
// Classed multi-queue buffer
// FIFO queues per zone and size class sharing one entry buffer.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_item (req_item_t)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_item (rsp_item_t)
//   cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// An enqueue, an empty dequeue or any rejected item goes from accept to commit;
// a nonempty dequeue adds a fetch, as the head pointer read must finish before
// the entry and link memories are read there, via single registered ports.
// Reset leaves all queues empty and the free list full; no clearing pass runs.
// A stalled result holds the commit step, and with it the next acceptance.
// ----------------------------------------------------------------------------
module classed_multi_queue_buffer_top #(
	parameter int NUM_ZONES      = cmqb_pkg::NUM_ZONES_DEF,
	parameter int NUM_CLASSES    = cmqb_pkg::NUM_CLASSES_DEF,
	parameter int BUFFER_ENTRIES = cmqb_pkg::BUFFER_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  cmqb_pkg::req_item_t            req_item,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output cmqb_pkg::rsp_item_t            rsp_item,
	input  logic                           cfg_we,
	input  logic [cmqb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cmqb_pkg::LIMIT_W-1:0]   cfg_data
);
	import cmqb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cmqb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cmqb_datapath #(
		.NUM_ZONES      (NUM_ZONES),
		.NUM_CLASSES    (NUM_CLASSES),
		.BUFFER_ENTRIES (BUFFER_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

`include "assert_macros.svh"

	`ASSERT_NEXT(a_accept_blocks, clk, arst_n, req_valid && !req_stall, req_stall)
	`ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.exec, rsp_valid)
	`ASSERT_NEXT(a_fetch_then_commit, clk, arst_n, cmd.fetch, cmd.exec || stat.out_busy)
	`ASSERT_ALWAYS(a_no_commit_busy, clk, arst_n, !(cmd.exec && rsp_valid && rsp_stall))

endmodule
